// File: rtl/vcct_pkg.sv
// ----------------------------------------------------------------------------
// vcct_pkg
// Shared sizes, operation and status codes and entry types of the
// virtual channel credit table.
// ----------------------------------------------------------------------------
package vcct_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int CREDIT_BITS  = 16;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // stream payload widths
  localparam int VC_W       = 3;
  localparam int FIELD_W    = 16;
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 56;

  typedef logic [CREDIT_BITS-1:0] credit_t;
  typedef logic [CH_W-1:0]        chan_idx_t;

  typedef enum logic [1:0] {
    FN_CONSUME = 2'd0,
    FN_RETURN  = 2'd1,
    FN_SET     = 2'd2,
    FN_QUERY   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_INIT  = 2'd1,
    ST_NO_CREDIT = 2'd2
  } status_t;

  typedef struct packed {
    logic    valid;
    credit_t total;
    credit_t avail;
    credit_t pend;
  } chan_entry_t;

  typedef struct packed {
    logic        en;
    chan_idx_t   idx;
    chan_entry_t entry;
  } chan_wr_t;

  typedef struct packed {
    logic               became_available;
    logic [FIELD_W-1:0] new_pending;
    logic [FIELD_W-1:0] new_available;
    logic [FIELD_W-1:0] old_available;
    status_t            status;
  } result_t;

endpackage

// File: rtl/virtual_channel_credit_table.sv
// ----------------------------------------------------------------------------
// virtual_channel_credit_table
// Credit counters per virtual channel with consume, return and set operations.
// ----------------------------------------------------------------------------
// pipeline: the input register, then one pass of table read and update into
//   the result register; 1 operation per cycle unless the output stalls. The
//   table write of one operation lands at the same edge as its result, so the
//   next operation reads updated state
// reset: synchronous active-low rst_n clears all channel entries and both
//   pipeline valid flags; items are accepted from the first cycle after reset
module virtual_channel_credit_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [vcct_pkg::IN_DATA_W-1:0]    in_tdata,   // vc[2:0], amount[18:3]
  input  logic [vcct_pkg::IN_USER_W-1:0]    in_tuser,   // func[1:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status[1:0], old_available[17:2], new_available[33:18],
  // new_pending[49:34], became_available[50]
  output logic [vcct_pkg::OUT_DATA_W-1:0]   out_tdata
);
  import vcct_pkg::*;

  logic               s1_valid_r;
  func_t              s1_func_r;
  logic [VC_W-1:0]    s1_vc_r;
  logic [FIELD_W-1:0] s1_amount_r;
  logic               out_valid_r;
  result_t            out_res_r;

  logic        advance;
  chan_entry_t rd_entry;
  chan_wr_t    calc_wr;
  chan_wr_t    tbl_wr;
  result_t     calc_res;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_func_r   <= func_t'(in_tuser[1:0]);
      s1_vc_r     <= in_tdata[VC_W-1:0];
      s1_amount_r <= in_tdata[VC_W+FIELD_W-1:VC_W];
    end
    if (advance) begin
      out_res_r <= calc_res;
    end
  end

  vcct_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (chan_idx_t'(s1_vc_r)),
    .rd_entry (rd_entry),
    .wr       (tbl_wr)
  );

  vcct_calc u_calc (
    .func     (s1_func_r),
    .vc       (s1_vc_r),
    .amount   (s1_amount_r),
    .rd_entry (rd_entry),
    .wr       (calc_wr),
    .res      (calc_res)
  );

  // state is committed only when the result moves into the output register
  always_comb begin
    tbl_wr    = calc_wr;
    tbl_wr.en = calc_wr.en && advance;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r};

endmodule

// File: rtl/vcct_table.sv
// ----------------------------------------------------------------------------
// vcct_table
// Per-channel credit state in flip-flops: one read port, one write port.
// ----------------------------------------------------------------------------
module vcct_table (
  input  logic                  clk,
  input  logic                  rst_n,
  input  vcct_pkg::chan_idx_t   rd_idx,
  output vcct_pkg::chan_entry_t rd_entry,
  input  vcct_pkg::chan_wr_t    wr
);
  import vcct_pkg::*;

  chan_entry_t entry_r [NUM_CHANNELS];

  assign rd_entry = entry_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        entry_r[i] <= '0;
      end
    end else if (wr.en) begin
      entry_r[wr.idx] <= wr.entry;
    end
  end

endmodule

// File: rtl/vcct_calc.sv
// ----------------------------------------------------------------------------
// vcct_calc
// Single-pass update of one channel entry for consume, return, set and query.
// ----------------------------------------------------------------------------
module vcct_calc (
  input  vcct_pkg::func_t             func,
  input  logic [vcct_pkg::VC_W-1:0]   vc,
  input  logic [vcct_pkg::FIELD_W-1:0] amount,
  input  vcct_pkg::chan_entry_t       rd_entry,
  output vcct_pkg::chan_wr_t          wr,
  output vcct_pkg::result_t           res
);
  import vcct_pkg::*;

  logic                         in_range;
  credit_t                      amt;
  credit_t                      oa;
  credit_t                      na;
  credit_t                      np;
  credit_t                      set_na;
  credit_t                      ret_na;
  credit_t                      ret_np;
  logic signed [CREDIT_BITS+1:0] set_sum;
  logic [CREDIT_BITS:0]         ret_sum;
  status_t                      st;
  logic                         became;

  assign in_range = (32'(vc) < NUM_CHANNELS);
  assign amt      = credit_t'(amount);
  assign oa       = rd_entry.avail;

  // shift available by the change in total, then clamp to 0..amount
  assign set_sum = $signed({2'b00, oa}) + $signed({2'b00, amt})
                 - $signed({2'b00, rd_entry.total});

  always_comb begin
    if (set_sum[CREDIT_BITS+1]) begin
      set_na = '0;
    end else if (set_sum[CREDIT_BITS:0] > {1'b0, amt}) begin
      set_na = amt;
    end else begin
      set_na = set_sum[CREDIT_BITS-1:0];
    end
  end

  assign ret_sum = {1'b0, oa} + {1'b0, amt};
  assign ret_na  = (ret_sum > {1'b0, rd_entry.total}) ? rd_entry.total
                                                       : ret_sum[CREDIT_BITS-1:0];
  assign ret_np  = (rd_entry.pend >= amt) ? (rd_entry.pend - amt) : '0;

  always_comb begin
    wr.en    = 1'b0;
    wr.idx   = chan_idx_t'(vc);
    wr.entry = rd_entry;
    st       = ST_DONE;
    na       = oa;
    np       = rd_entry.pend;
    became   = 1'b0;
    if (!in_range) begin
      st = ST_NOT_INIT;
      na = '0;
      np = '0;
    end else if (func == FN_SET) begin
      wr.en = 1'b1;
      if (!rd_entry.valid) begin
        na = amt;
        np = '0;
      end else begin
        na = set_na;
      end
      wr.entry.valid = 1'b1;
      wr.entry.total = amt;
      wr.entry.avail = na;
      wr.entry.pend  = np;
    end else if (!rd_entry.valid) begin
      st = ST_NOT_INIT;
    end else begin
      case (func)
        FN_CONSUME: begin
          if (oa == '0) begin
            st = ST_NO_CREDIT;
          end else begin
            wr.en = 1'b1;
            na    = oa - credit_t'(1);
            // pending saturates at its maximum
            if (rd_entry.pend != '1) begin
              np = rd_entry.pend + credit_t'(1);
            end
            wr.entry.avail = na;
            wr.entry.pend  = np;
          end
        end
        FN_RETURN: begin
          wr.en          = 1'b1;
          na             = ret_na;
          np             = ret_np;
          became         = (oa == '0) && (ret_na != '0);
          wr.entry.avail = na;
          wr.entry.pend  = np;
        end
        default: begin
          st = ST_DONE;
        end
      endcase
    end
  end

  assign res.status           = st;
  assign res.old_available    = in_range ? FIELD_W'(oa) : '0;
  assign res.new_available    = FIELD_W'(na);
  assign res.new_pending      = FIELD_W'(np);
  assign res.became_available = became;

endmodule

// File: verif/credit_table_checker.sv
// ----------------------------------------------------------------------------
// credit_table_checker
// Watches both stream channels of the virtual channel credit table. It keeps
// its own copy of the per-channel credit counters, works out the expected
// result of every accepted operation and compares each result transfer
// field by field, in order.
// ----------------------------------------------------------------------------
module credit_table_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [vcct_pkg::IN_DATA_W-1:0]  in_tdata,   // vc[2:0], amount[18:3]
  input  logic [vcct_pkg::IN_USER_W-1:0]  in_tuser,   // func[1:0]
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // status[1:0], old_available[17:2], new_available[33:18],
  // new_pending[49:34], became_available[50]
  input  logic [vcct_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              errors,
  output int                              n_expected
);
  timeunit 1ns;
  timeprecision 1ps;

  import vcct_pkg::*;

  localparam int      MAX_PRINTED = 20;
  localparam credit_t CREDIT_MAX  = '1;

  logic    ch_init  [NUM_CHANNELS];
  credit_t ch_total [NUM_CHANNELS];
  credit_t ch_avail [NUM_CHANNELS];
  credit_t ch_pend  [NUM_CHANNELS];

  result_t expected_q[$];

  task automatic report_error(string msg);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("%0t ns: credit table mismatch: %s", $realtime, msg);
    end
  endtask

  // applies one operation to the shadow table and returns its result
  function automatic result_t apply_credit_op(func_t f, logic [VC_W-1:0] v, credit_t amt);
    result_t r;
    int      c;
    longint  nv;
    r = '0;
    r.status = ST_NOT_INIT;
    if (v >= NUM_CHANNELS) begin
      return r;
    end
    c = int'(v);
    r.status = ST_DONE;
    r.old_available = FIELD_W'(ch_avail[c]);
    if (f == FN_SET) begin
      if (!ch_init[c]) begin
        ch_init[c]  = 1'b1;
        ch_total[c] = amt;
        ch_avail[c] = amt;
        ch_pend[c]  = '0;
      end else begin
        // shift by the change in total, then clamp to 0..total
        nv = longint'(ch_avail[c]) + longint'(amt) - longint'(ch_total[c]);
        if (nv < 0) begin
          nv = 0;
        end
        if (nv > longint'(amt)) begin
          nv = longint'(amt);
        end
        ch_total[c] = amt;
        ch_avail[c] = credit_t'(nv);
      end
    end else if (!ch_init[c]) begin
      r.status = ST_NOT_INIT;
    end else if (f == FN_CONSUME) begin
      if (ch_avail[c] == '0) begin
        r.status = ST_NO_CREDIT;
      end else begin
        ch_avail[c] = ch_avail[c] - credit_t'(1);
        if (ch_pend[c] != CREDIT_MAX) begin
          ch_pend[c] = ch_pend[c] + credit_t'(1);
        end
      end
    end else if (f == FN_RETURN) begin
      nv = longint'(ch_avail[c]) + longint'(amt);
      if (nv > longint'(ch_total[c])) begin
        nv = longint'(ch_total[c]);
      end
      r.became_available = (ch_avail[c] == '0) && (nv > 0);
      ch_avail[c] = credit_t'(nv);
      ch_pend[c]  = (ch_pend[c] >= amt) ? ch_pend[c] - amt : '0;
    end
    r.new_available = FIELD_W'(ch_avail[c]);
    r.new_pending   = FIELD_W'(ch_pend[c]);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ch_init[i]  = 1'b0;
        ch_total[i] = '0;
        ch_avail[i] = '0;
        ch_pend[i]  = '0;
      end
      expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[$bits(result_t)-1:0]);
        if (expected_q.size() == 0) begin
          report_error("result transfer with no expected result waiting");
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status) begin
            report_error($sformatf("status got %0d, expected %0d", got.status, want.status));
          end
          if (got.old_available !== want.old_available) begin
            report_error($sformatf("old_available got %0d, expected %0d",
                                   got.old_available, want.old_available));
          end
          if (got.new_available !== want.new_available) begin
            report_error($sformatf("new_available got %0d, expected %0d",
                                   got.new_available, want.new_available));
          end
          if (got.new_pending !== want.new_pending) begin
            report_error($sformatf("new_pending got %0d, expected %0d",
                                   got.new_pending, want.new_pending));
          end
          if (got.became_available !== want.became_available) begin
            report_error($sformatf("became_available got %0b, expected %0b",
                                   got.became_available, want.became_available));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_q.push_back(apply_credit_op(func_t'(in_tuser), in_tdata[VC_W-1:0],
                                             credit_t'(in_tdata[VC_W +: FIELD_W])));
      end
    end
    n_expected <= expected_q.size();
  end

endmodule

// File: verif/virtual_channel_credit_table_test.sv
// ----------------------------------------------------------------------------
// virtual_channel_credit_table_test
// Drives consume, return, set and query operations into the credit table:
// a directed pass over the corner cases, then random traffic with idle
// bursts on both sides and one long output hold-off. Checking is done by
// credit_table_checker.
// ----------------------------------------------------------------------------
module virtual_channel_credit_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vcct_pkg::*;

  localparam int RAND_OPS       = 850;
  localparam int QUIET_TAIL     = 120;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 10;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;  // vc[2:0], amount[18:3]
  logic [IN_USER_W-1:0]  in_tuser  = '0;  // func[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // status[1:0], old_available[17:2], new_available[33:18],
  // new_pending[49:34], became_available[50]
  logic [OUT_DATA_W-1:0] out_tdata;

  int errors;
  int n_expected;
  int stall_count = 0;
  bit tx_gaps     = 1'b1;
  bit rx_gaps     = 1'b1;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;

  virtual_channel_credit_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  credit_table_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .errors    (errors),
    .n_expected(n_expected)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_count <= 0;
    end else if (stall_count >= WATCHDOG_LIMIT) begin
      $display("virtual_channel_credit_table_test: done, errors");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // result side: random idle bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_op(func_t f, logic [VC_W-1:0] v, logic [FIELD_W-1:0] a);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= IN_DATA_W'({a, v});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    func_t            f;
    logic [VC_W-1:0]  v;
    logic [FIELD_W-1:0] a;
    int               pick;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // corner cases on fresh and initialized channels
    send_op(FN_CONSUME, 3'd0, 16'hFFFF);  // not initialized
    send_op(FN_RETURN, 3'd0, 16'd5);
    send_op(FN_QUERY, 3'd1, 16'd0);
    send_op(FN_SET, 3'd0, 16'd3);
    send_op(FN_QUERY, 3'd0, 16'd0);
    repeat (3) send_op(FN_CONSUME, 3'd0, 16'd0);
    send_op(FN_CONSUME, 3'd0, 16'd0);         // no credit left
    send_op(FN_RETURN, 3'd0, 16'd0);
    send_op(FN_RETURN, 3'd0, 16'd1);          // rises from zero
    send_op(FN_RETURN, 3'd0, 16'hFFFF);       // capped, pending floors at zero
    repeat (2) send_op(FN_CONSUME, 3'd0, 16'd0);
    send_op(FN_SET, 3'd0, 16'd0);             // shrink below available
    send_op(FN_RETURN, 3'd0, 16'd2);          // total is zero, stays empty
    send_op(FN_SET, 3'd0, 16'hFFFF);
    send_op(FN_SET, 3'd7, 16'hFFFF);
    send_op(FN_SET, 3'd7, 16'h5555);
    send_op(FN_SET, 3'd3, 16'd0);
    send_op(FN_CONSUME, 3'd3, 16'hAAAA);
    send_op(FN_SET, 3'd5, 16'hAAAA);
    send_op(FN_QUERY, 3'd5, 16'hFFFF);

    for (int i = 0; i < RAND_OPS; i++) begin
      if (i == HOLD_AT) begin
        hold_req = 1'b1;
        tx_gaps = 1'b0;
      end
      if (i == HOLD_AT + 40) begin
        tx_gaps = 1'b1;
      end
      if (i == RAND_OPS - QUIET_TAIL) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        f = FN_CONSUME;
      end else if (pick < 65) begin
        f = FN_RETURN;
      end else if (pick < 90) begin
        f = FN_SET;
      end else begin
        f = FN_QUERY;
      end
      v = VC_W'($urandom_range(0, NUM_CHANNELS - 1));
      // mostly small credit counts so channels run dry and refill often
      if (f == FN_CONSUME || f == FN_QUERY || $urandom_range(0, 9) == 0) begin
        a = FIELD_W'($urandom_range(0, 16'hFFFF));
      end else if (f == FN_SET) begin
        a = FIELD_W'($urandom_range(0, 12));
      end else begin
        a = FIELD_W'($urandom_range(0, 4));
      end
      send_op(f, v, a);
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (n_expected != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && n_expected == 0) begin
      $display("virtual_channel_credit_table_test: done, clean");
    end else begin
      $display("virtual_channel_credit_table_test: done, errors");
    end
    $finish;
  end

endmodule
